>>> rtl/tpms_pkg.sv
// shared types and codes for the two-phase motor maneuver sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tpms_pkg;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_REV    = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_BRAKE  = 2'd3;

  // maneuver codes
  localparam logic [1:0] MAN_FWD   = 2'd0;
  localparam logic [1:0] MAN_RIGHT = 2'd1;
  localparam logic [1:0] MAN_LEFT  = 2'd2;
  localparam logic [1:0] MAN_NONE  = 2'd3;

  // item kinds
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // register indexes
  localparam logic [2:0] REG_REVERSE_MS_TURN     = 3'd0;
  localparam logic [2:0] REG_REVERSE_MS_STRAIGHT = 3'd1;
  localparam logic [2:0] REG_FORWARD_MS          = 3'd2;
  localparam logic [2:0] REG_TURN_MS             = 3'd3;
  localparam logic [2:0] REG_REVERSE_SPEED       = 3'd4;
  localparam logic [2:0] REG_FORWARD_SPEED       = 3'd5;
  localparam logic [2:0] REG_TURN_SPEED          = 3'd6;
  localparam logic [2:0] REG_RAMP_STEP           = 3'd7;

  typedef struct packed {
    logic [15:0] reverse_ms_turn;
    logic [15:0] reverse_ms_straight;
    logic [15:0] forward_ms;
    logic [15:0] turn_ms;
    logic [7:0]  reverse_speed;
    logic [7:0]  forward_speed;
    logic [7:0]  turn_speed;
    logic [7:0]  ramp_step;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] left_drive;
    logic signed [8:0] right_drive;
    logic [1:0]        phase;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/tpms_cfg_regs.sv
// configuration register file of the maneuver sequencer
// depends on tpms_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpms_cfg_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output tpms_pkg::cfg_t         cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_ms_turn     <= 16'd500;
      cfg.reverse_ms_straight <= 16'd500;
      cfg.forward_ms          <= 16'd500;
      cfg.turn_ms             <= 16'd500;
      cfg.reverse_speed       <= 8'd150;
      cfg.forward_speed       <= 8'd150;
      cfg.turn_speed          <= 8'd150;
      cfg.ramp_step           <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpms_pkg::REG_REVERSE_MS_TURN:     cfg.reverse_ms_turn     <= cfg_data;
        tpms_pkg::REG_REVERSE_MS_STRAIGHT: cfg.reverse_ms_straight <= cfg_data;
        tpms_pkg::REG_FORWARD_MS:          cfg.forward_ms          <= cfg_data;
        tpms_pkg::REG_TURN_MS:             cfg.turn_ms             <= cfg_data;
        tpms_pkg::REG_REVERSE_SPEED:       cfg.reverse_speed       <= cfg_data[7:0];
        tpms_pkg::REG_FORWARD_SPEED:       cfg.forward_speed       <= cfg_data[7:0];
        tpms_pkg::REG_TURN_SPEED:          cfg.turn_speed          <= cfg_data[7:0];
        tpms_pkg::REG_RAMP_STEP:           cfg.ramp_step           <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tpms_engine.sv
// maneuver state, phase timer and drive ramps; one item per enabled cycle
// depends on tpms_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpms_engine (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic         req_type,
  input  wire logic [1:0]   maneuver,
  input  wire logic [7:0]   ms_passed,
  input  wire tpms_pkg::cfg_t cfg,
  output tpms_pkg::res_t    res
);

  logic [1:0]        phase_reg, phase_reg_next;
  logic [1:0]        maneuver_reg, maneuver_reg_next;
  logic [31:0]       phase_timer, phase_timer_next;
  logic signed [8:0] left_level, left_level_next;
  logic signed [8:0] right_level, right_level_next;

  logic [7:0]        step;
  logic [32:0]       tsum;
  logic [31:0]       tsat;
  logic              straight;
  logic [15:0]       dur_rev;
  logic [15:0]       dur_second;
  logic signed [8:0] tgt_rev;
  logic signed [8:0] tgt_fwd;
  logic signed [8:0] tgt_turn;
  logic signed [8:0] tgt_left;
  logic signed [8:0] tgt_right;
  logic signed [8:0] ramp_left;
  logic signed [8:0] ramp_right;

  // move cur at most step toward tgt
  function automatic logic signed [8:0] ramp(input logic signed [8:0] cur,
                                             input logic signed [8:0] tgt,
                                             input logic [7:0] stp);
    logic signed [10:0] up;
    logic signed [10:0] dn;
    logic signed [10:0] tg;
    logic signed [8:0]  r;
    up = 11'(cur) + $signed({3'b000, stp});
    dn = 11'(cur) - $signed({3'b000, stp});
    tg = 11'(tgt);
    if (cur < tgt) begin
      r = (up > tg) ? tgt : up[8:0];
    end else if (cur > tgt) begin
      r = (dn < tg) ? tgt : dn[8:0];
    end else begin
      r = cur;
    end
    return r;
  endfunction

  assign step     = (cfg.ramp_step == 8'd0) ? 8'd1 : cfg.ramp_step;
  assign straight = (maneuver_reg == tpms_pkg::MAN_FWD);
  assign tsum     = {1'b0, phase_timer} + {25'd0, ms_passed};
  assign tsat     = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

  assign dur_rev    = straight ? cfg.reverse_ms_straight : cfg.reverse_ms_turn;
  assign dur_second = straight ? cfg.forward_ms : cfg.turn_ms;

  assign tgt_rev  = -$signed({1'b0, cfg.reverse_speed});
  assign tgt_fwd  = $signed({1'b0, cfg.forward_speed});
  assign tgt_turn = $signed({1'b0, cfg.turn_speed});

  // targets of the current phase
  always_comb begin
    tgt_left  = 9'sd0;
    tgt_right = 9'sd0;
    case (phase_reg)
      tpms_pkg::PH_REV: begin
        tgt_left  = tgt_rev;
        tgt_right = tgt_rev;
      end
      tpms_pkg::PH_SECOND: begin
        case (maneuver_reg)
          tpms_pkg::MAN_FWD: begin
            tgt_left  = tgt_fwd;
            tgt_right = tgt_fwd;
          end
          tpms_pkg::MAN_RIGHT: begin
            tgt_left  = tgt_turn;
            tgt_right = -tgt_turn;
          end
          default: begin
            tgt_left  = -tgt_turn;
            tgt_right = tgt_turn;
          end
        endcase
      end
      default: begin
        tgt_left  = 9'sd0;
        tgt_right = 9'sd0;
      end
    endcase
  end

  assign ramp_left  = ramp(left_level, tgt_left, step);
  assign ramp_right = ramp(right_level, tgt_right, step);

  always_comb begin
    phase_reg_next    = phase_reg;
    maneuver_reg_next = maneuver_reg;
    phase_timer_next  = phase_timer;
    left_level_next   = left_level;
    right_level_next  = right_level;
    if (req_type == tpms_pkg::REQ_START) begin
      if (maneuver != tpms_pkg::MAN_NONE) begin
        if (phase_reg != tpms_pkg::PH_IDLE && maneuver_reg == maneuver) begin
          // cancel, drives hold
          phase_reg_next    = tpms_pkg::PH_IDLE;
          maneuver_reg_next = tpms_pkg::MAN_NONE;
        end else begin
          phase_reg_next    = tpms_pkg::PH_REV;
          maneuver_reg_next = maneuver;
          phase_timer_next  = 32'd0;
        end
      end
    end else begin
      phase_timer_next = tsat;
      if (phase_reg != tpms_pkg::PH_IDLE) begin
        left_level_next  = ramp_left;
        right_level_next = ramp_right;
      end
      unique case (phase_reg)
        tpms_pkg::PH_REV: begin
          if (tsat >= {16'd0, dur_rev}) begin
            phase_reg_next   = tpms_pkg::PH_SECOND;
            phase_timer_next = 32'd0;
          end
        end
        tpms_pkg::PH_SECOND: begin
          if (tsat >= {16'd0, dur_second}) begin
            phase_reg_next = tpms_pkg::PH_BRAKE;
          end
        end
        tpms_pkg::PH_BRAKE: begin
          if (ramp_left == 9'sd0 && ramp_right == 9'sd0) begin
            phase_reg_next    = tpms_pkg::PH_IDLE;
            maneuver_reg_next = tpms_pkg::MAN_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= tpms_pkg::PH_IDLE;
      maneuver_reg <= tpms_pkg::MAN_NONE;
      phase_timer  <= 32'd0;
      left_level   <= 9'sd0;
      right_level  <= 9'sd0;
    end else if (go) begin
      phase_reg    <= phase_reg_next;
      maneuver_reg <= maneuver_reg_next;
      phase_timer  <= phase_timer_next;
      left_level   <= left_level_next;
      right_level  <= right_level_next;
    end
  end

  assign res.left_drive  = left_level;
  assign res.right_drive = right_level;
  assign res.phase       = phase_reg;

`ifndef SYNTHESIS
  a_idle_no_maneuver: assert property (@(posedge clk) disable iff (rst)
    (phase_reg == tpms_pkg::PH_IDLE) |-> (maneuver_reg == tpms_pkg::MAN_NONE))
    else $error("idle phase with a maneuver still held");

  a_busy_has_maneuver: assert property (@(posedge clk) disable iff (rst)
    (phase_reg != tpms_pkg::PH_IDLE) |-> (maneuver_reg != tpms_pkg::MAN_NONE))
    else $error("active phase without a maneuver");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    (left_level != -9'sd256) && (right_level != -9'sd256))
    else $error("drive level out of range");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (go && req_type == tpms_pkg::REQ_TICK && phase_reg == tpms_pkg::PH_IDLE)
    |=> (left_level == $past(left_level) && right_level == $past(right_level)
         && phase_reg == tpms_pkg::PH_IDLE))
    else $error("idle tick changed the drives or phase");
`endif

endmodule

`default_nettype wire

>>> rtl/two_phase_motor_maneuver_sequencer_core.sv
// an accepted item beat waits in the item register, then its result is offered from the state registers
// throughput: one item per cycle when not stalled; set by the single step pass between the
//   item register and the state registers, which also hold the result
// reset (rst, synchronous): idle phase, no maneuver, timer and drives zero,
//   configuration back to its defaults, both pipeline slots empty
`timescale 1ns / 1ps
`default_nettype none

module two_phase_motor_maneuver_sequencer_core (
  input  wire logic              clk,
  input  wire logic              rst,
  // item channel
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic              req_type,
  input  wire logic [1:0]        maneuver,
  input  wire logic [7:0]        ms_passed,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output logic signed [8:0]      left_drive,
  output logic signed [8:0]      right_drive,
  output logic [1:0]             phase,
  // configuration write channel
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);

  tpms_pkg::cfg_t cfg;
  tpms_pkg::res_t res;

  // item register
  logic       held_valid;
  logic       held_req_type;
  logic [1:0] held_maneuver;
  logic [7:0] held_ms_passed;

  // the held item moves into the state when the result slot is free or
  // its current beat is being taken this cycle
  logic advance;
  logic take;

  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      held_req_type  <= req_type;
      held_maneuver  <= maneuver;
      held_ms_passed <= ms_passed;
    end
  end

  // result slot flag; the payload is the engine state itself, which only
  // moves on advance, so a stalled beat holds
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  tpms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tpms_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .go        (advance),
    .req_type  (held_req_type),
    .maneuver  (held_maneuver),
    .ms_passed (held_ms_passed),
    .cfg       (cfg),
    .res       (res)
  );

  assign left_drive  = res.left_drive;
  assign right_drive = res.right_drive;
  assign phase       = res.phase;

endmodule

`default_nettype wire

>>> test/tb_two_phase_motor_maneuver_sequencer_core.sv
// testbench for two_phase_motor_maneuver_sequencer_core: a start, cancel and tick beat stream,
// with a shadow sequencer that predicts drive levels and phase for every accepted beat
// depends on tpms_pkg and the core; reads no files
`timescale 1ns / 1ps

module tb_two_phase_motor_maneuver_sequencer_core;

  // one row of the directed script; want is used only when typed is set
  typedef struct packed {
    logic           rq;
    logic [1:0]     mn;
    logic [7:0]     ms;
    logic           typed;
    tpms_pkg::res_t want;
  } script_row_t;

  localparam int SCRIPT_LEN   = 25;
  localparam int RANDOM_BEATS = 1650;
  localparam int PHASE_BEATS  = 130;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // item channel
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              req_type   = tpms_pkg::REQ_TICK;
  logic [1:0]        maneuver   = tpms_pkg::MAN_NONE;
  logic [7:0]        ms_passed  = 8'd0;
  // result channel
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic signed [8:0] left_drive;
  logic signed [8:0] right_drive;
  logic [1:0]        phase;
  // configuration channel
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = tpms_pkg::REG_REVERSE_MS_TURN;
  logic [15:0]       cfg_data  = 16'd0;

  // shadow copy of the sequencer: configuration, phase, maneuver, timer, drive levels
  tpms_pkg::cfg_t shadow_cfg;
  logic [1:0]     shadow_phase;
  logic [1:0]     shadow_man;
  logic [31:0]    shadow_timer;
  int             shadow_left;
  int             shadow_right;

  // drive states predicted for accepted beats, oldest first
  tpms_pkg::res_t pending_drive_states [$];

  int errors        = 0;
  int beats_sent    = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  bit quiet         = 1'b0;  // no random idling on either side while set
  int noise_pct     = 4;     // chance of a stray start/cancel beat in a maneuver
  int ms_hi_pct     = 15;    // chance of a full 255 ms tick

  two_phase_motor_maneuver_sequencer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .req_type     (req_type),
    .maneuver     (maneuver),
    .ms_passed    (ms_passed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .left_drive   (left_drive),
    .right_drive  (right_drive),
    .phase        (phase),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the handshakes lock up
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    // keep the log bounded if the core is badly broken
    if (errors < 100) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // move one drive level at most stp toward its target
  function automatic int slew(input int cur, input int tgt, input int stp);
    int lvl;
    lvl = cur;
    if (lvl < tgt) begin
      lvl += stp;
      if (lvl > tgt) lvl = tgt;
    end else if (lvl > tgt) begin
      lvl -= stp;
      if (lvl < tgt) lvl = tgt;
    end
    return lvl;
  endfunction

  // advance the shadow sequencer by one beat and return the drive state it leaves
  function automatic tpms_pkg::res_t predict_drive_state(input logic rq,
                                                         input logic [1:0] mn,
                                                         input logic [7:0] ms);
    int             stp;
    int             tl;
    int             tr;
    logic [32:0]    sum;
    logic [15:0]    dur;
    logic           straight;
    tpms_pkg::res_t r;
    // a zero ramp step still moves by one so braking always ends
    stp      = (shadow_cfg.ramp_step == 8'd0) ? 1 : int'(shadow_cfg.ramp_step);
    straight = (shadow_man == tpms_pkg::MAN_FWD);
    if (rq == tpms_pkg::REQ_START) begin
      // code three is ignored; same maneuver while running cancels, anything else restarts
      if (mn != tpms_pkg::MAN_NONE) begin
        if (shadow_phase != tpms_pkg::PH_IDLE && shadow_man == mn) begin
          shadow_phase = tpms_pkg::PH_IDLE;
          shadow_man   = tpms_pkg::MAN_NONE;
        end else begin
          shadow_man   = mn;
          shadow_phase = tpms_pkg::PH_REV;
          shadow_timer = '0;
        end
      end
    end else begin
      // timer saturates, and counts in every phase, idle included
      sum          = {1'b0, shadow_timer} + {25'd0, ms};
      shadow_timer = sum[32] ? '1 : sum[31:0];
      case (shadow_phase)
        tpms_pkg::PH_REV: begin
          tl  = -int'(shadow_cfg.reverse_speed);
          dur = straight ? shadow_cfg.reverse_ms_straight : shadow_cfg.reverse_ms_turn;
          shadow_left  = slew(shadow_left, tl, stp);
          shadow_right = slew(shadow_right, tl, stp);
          if (shadow_timer >= {16'd0, dur}) begin
            shadow_phase = tpms_pkg::PH_SECOND;
            shadow_timer = '0;
          end
        end
        tpms_pkg::PH_SECOND: begin
          dur = straight ? shadow_cfg.forward_ms : shadow_cfg.turn_ms;
          if (shadow_man == tpms_pkg::MAN_FWD) begin
            tl = int'(shadow_cfg.forward_speed);
            tr = tl;
          end else if (shadow_man == tpms_pkg::MAN_RIGHT) begin
            tl = int'(shadow_cfg.turn_speed);
            tr = -tl;
          end else begin
            tr = int'(shadow_cfg.turn_speed);
            tl = -tr;
          end
          shadow_left  = slew(shadow_left, tl, stp);
          shadow_right = slew(shadow_right, tr, stp);
          if (shadow_timer >= {16'd0, dur}) shadow_phase = tpms_pkg::PH_BRAKE;
        end
        tpms_pkg::PH_BRAKE: begin
          shadow_left  = slew(shadow_left, 0, stp);
          shadow_right = slew(shadow_right, 0, stp);
          if (shadow_left == 0 && shadow_right == 0) begin
            shadow_phase = tpms_pkg::PH_IDLE;
            shadow_man   = tpms_pkg::MAN_NONE;
          end
        end
        default: ;  // idle ticks hold the drives
      endcase
    end
    r.left_drive  = shadow_left[8:0];
    r.right_drive = shadow_right[8:0];
    r.phase       = shadow_phase;
    return r;
  endfunction

  // offer one item beat after a random gap; the beat is accepted when stall is low
  task automatic send_beat(input logic rq, input logic [1:0] mn, input logic [7:0] ms,
                           input logic typed, input tpms_pkg::res_t want);
    tpms_pkg::res_t predicted;
    while (!quiet && $urandom_range(0, 99) < 23) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    req_type   <= rq;
    maneuver   <= mn;
    ms_passed  <= ms;
    do @(posedge clk); while (item_stall);
    predicted = predict_drive_state(rq, mn, ms);
    pending_drive_states.push_back(typed ? want : predicted);
    // code-three starts do nothing, so they do not count
    if (!(rq == tpms_pkg::REQ_START && mn == tpms_pkg::MAN_NONE)) beats_sent++;
  endtask

  task automatic send_tick();
    logic [7:0]  ms;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < ms_hi_pct) ms = 8'd255;
    else if (pick < ms_hi_pct + 8) ms = 8'd0;
    else if (pick < ms_hi_pct + 18) ms = 8'($urandom_range(1, 15));
    else ms = 8'($urandom_range(0, 255));
    // maneuver field is a don't-care on ticks
    send_beat(tpms_pkg::REQ_TICK, 2'($urandom_range(0, 3)), ms, 1'b0, '0);
  endtask

  // one start followed by ticks until the sequencer is idle again, with stray requests
  task automatic run_maneuver();
    int n;
    n = 0;
    send_beat(tpms_pkg::REQ_START,
              ($urandom_range(0, 19) == 0) ? tpms_pkg::MAN_NONE : 2'($urandom_range(0, 2)),
              8'($urandom_range(0, 255)), 1'b0, '0);
    while (shadow_phase != tpms_pkg::PH_IDLE && n < 1200) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(tpms_pkg::REQ_START, 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 1'b0, '0);
      else
        send_tick();
      n++;
    end
    // a few idle ticks now and then
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_tick();
  endtask

  // let the core drain, then write all eight registers in index order
  task automatic retune(input logic [7:0][15:0] v);
    item_valid <= 1'b0;
    while (pending_drive_states.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= v[i];
      do @(posedge clk); while (!cfg_ready);
      // speed and step registers keep only the low byte
      case (3'(i))
        tpms_pkg::REG_REVERSE_MS_TURN:     shadow_cfg.reverse_ms_turn     = v[i];
        tpms_pkg::REG_REVERSE_MS_STRAIGHT: shadow_cfg.reverse_ms_straight = v[i];
        tpms_pkg::REG_FORWARD_MS:          shadow_cfg.forward_ms          = v[i];
        tpms_pkg::REG_TURN_MS:             shadow_cfg.turn_ms             = v[i];
        tpms_pkg::REG_REVERSE_SPEED:       shadow_cfg.reverse_speed       = v[i][7:0];
        tpms_pkg::REG_FORWARD_SPEED:       shadow_cfg.forward_speed       = v[i][7:0];
        tpms_pkg::REG_TURN_SPEED:          shadow_cfg.turn_speed          = v[i][7:0];
        tpms_pkg::REG_RAMP_STEP:           shadow_cfg.ramp_step           = v[i][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: check each accepted beat against the oldest prediction, then pick the
  // stall for the next cycle (random, none while quiet, solid during a hold-off)
  always @(posedge clk) begin : result_side
    tpms_pkg::res_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_drive_states.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected: l=%0d r=%0d ph=%0d",
                                left_drive, right_drive, phase));
      end else begin
        exp_r = pending_drive_states.pop_front();
        if (left_drive !== exp_r.left_drive)
          flag_mismatch($sformatf("left_drive %0d, expected %0d",
                                  left_drive, exp_r.left_drive));
        if (right_drive !== exp_r.right_drive)
          flag_mismatch($sformatf("right_drive %0d, expected %0d",
                                  right_drive, exp_r.right_drive));
        if (phase !== exp_r.phase)
          flag_mismatch($sformatf("phase %0d, expected %0d", phase, exp_r.phase));
      end
    end
    // a hold-off is counted here so the sender keeps pushing until the core backs up
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) hold_left--;
    result_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 23);
  end

  initial begin : stimulus
    script_row_t      script [0:SCRIPT_LEN-1];
    logic [7:0][15:0] settings;
    int               mark;

    // shadow starts at the reset state
    shadow_cfg.reverse_ms_turn     = 16'd500;
    shadow_cfg.reverse_ms_straight = 16'd500;
    shadow_cfg.forward_ms          = 16'd500;
    shadow_cfg.turn_ms             = 16'd500;
    shadow_cfg.reverse_speed       = 8'd150;
    shadow_cfg.forward_speed       = 8'd150;
    shadow_cfg.turn_speed          = 8'd150;
    shadow_cfg.ramp_step           = 8'd10;
    shadow_phase = tpms_pkg::PH_IDLE;
    shadow_man   = tpms_pkg::MAN_NONE;
    shadow_timer = '0;
    shadow_left  = 0;
    shadow_right = 0;

    // directed script under reset defaults; typed rows are obvious by inspection
    // idle tick holds zero drives, code three is ignored
    script[0]  = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b1,
                   '{9'sd0, 9'sd0, tpms_pkg::PH_IDLE}};
    script[1]  = '{tpms_pkg::REQ_START, tpms_pkg::MAN_NONE,  8'd0,   1'b1,
                   '{9'sd0, 9'sd0, tpms_pkg::PH_IDLE}};
    // start then cancel with the same maneuver
    script[2]  = '{tpms_pkg::REQ_START, tpms_pkg::MAN_FWD,   8'd255, 1'b1,
                   '{9'sd0, 9'sd0, tpms_pkg::PH_REV}};
    script[3]  = '{tpms_pkg::REQ_START, tpms_pkg::MAN_FWD,   8'd0,   1'b1,
                   '{9'sd0, 9'sd0, tpms_pkg::PH_IDLE}};
    // right turn: first tick ramps one step toward reverse
    script[4]  = '{tpms_pkg::REQ_START, tpms_pkg::MAN_RIGHT, 8'd0,   1'b1,
                   '{9'sd0, 9'sd0, tpms_pkg::PH_REV}};
    script[5]  = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd0,   1'b1,
                   '{-9'sd10, -9'sd10, tpms_pkg::PH_REV}};
    script[6]  = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_FWD,   8'd255, 1'b0, '0};
    script[7]  = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_LEFT,  8'd255, 1'b0, '0};
    script[8]  = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_RIGHT, 8'd255, 1'b0, '0};
    // restart with a different maneuver mid-turn, then cancel it; drives hold
    script[9]  = '{tpms_pkg::REQ_START, tpms_pkg::MAN_LEFT,  8'd0,   1'b0, '0};
    script[10] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_LEFT,  8'd255, 1'b0, '0};
    script[11] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd200, 1'b0, '0};
    // full back-forward run into the brake phase
    script[12] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_FWD,   8'd0,   1'b0, '0};
    script[13] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[14] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[15] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[16] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[17] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[18] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    // code three while braking and while running, then a cancel
    script[19] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_NONE,  8'd255, 1'b0, '0};
    script[20] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_RIGHT, 8'd0,   1'b0, '0};
    script[21] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_NONE,  8'd0,   1'b0, '0};
    script[22] = '{tpms_pkg::REQ_START, tpms_pkg::MAN_RIGHT, 8'd0,   1'b0, '0};
    script[23] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd128, 1'b0, '0};
    script[24] = '{tpms_pkg::REQ_TICK,  tpms_pkg::MAN_NONE,  8'd1,   1'b0, '0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_beat(script[i].rq, script[i].mn, script[i].ms, script[i].typed, script[i].want);

    // random part: one register setting per stretch, mostly complete maneuvers
    for (int k = 0; beats_sent < SCRIPT_LEN + RANDOM_BEATS; k++) begin
      noise_pct = 4;
      ms_hi_pct = 15;
      settings  = '0;
      case (k)
        0: settings = '0;  // zero durations, zero speeds, zero ramp step
        1: begin
          // every register at its top; ticks at full size so the long phases finish
          settings  = '1;
          noise_pct = 0;
          ms_hi_pct = 100;
        end
        2: begin
          // slowest ramp at full speed targets
          for (int i = tpms_pkg::REG_REVERSE_MS_TURN; i <= tpms_pkg::REG_TURN_MS; i++)
            settings[i] = 16'($urandom_range(0, 600));
          for (int i = tpms_pkg::REG_REVERSE_SPEED; i <= tpms_pkg::REG_TURN_SPEED; i++)
            settings[i] = 16'd255;
          settings[tpms_pkg::REG_RAMP_STEP] = 16'd1;
          noise_pct = 2;
        end
        default: begin
          for (int i = tpms_pkg::REG_REVERSE_MS_TURN; i <= tpms_pkg::REG_TURN_MS; i++)
            settings[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(0, 1500));
          // upper bytes of the byte-wide registers carry junk that must be dropped
          for (int i = tpms_pkg::REG_REVERSE_SPEED; i <= tpms_pkg::REG_TURN_SPEED; i++)
            settings[i] = 16'($urandom);
          settings[tpms_pkg::REG_RAMP_STEP] = ($urandom_range(0, 2) == 0)
                                              ? 16'($urandom_range(0, 4)) : 16'($urandom);
        end
      endcase
      retune(settings);
      // stretch 3: receiver holds off while the sender streams; stretch 5: no idling
      quiet = (k == 3 || k == 5);
      if (k == 3) hold_requests++;
      mark = beats_sent;
      while (beats_sent - mark < PHASE_BEATS && beats_sent < SCRIPT_LEN + RANDOM_BEATS)
        run_maneuver();
    end

    item_valid <= 1'b0;
    quiet = 1'b0;
    mark  = 0;
    while (pending_drive_states.size() != 0 && mark < 5000) begin
      @(posedge clk);
      mark++;
    end
    repeat (8) @(posedge clk);
    if (pending_drive_states.size() != 0)
      flag_mismatch($sformatf("%0d expected result beats never arrived",
                              pending_drive_states.size()));
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tpms_pkg.sv
rtl/tpms_cfg_regs.sv
rtl/tpms_engine.sv
rtl/two_phase_motor_maneuver_sequencer_core.sv
test/tb_two_phase_motor_maneuver_sequencer_core.sv
